// ----- rtl/sac_pkg.sv -----
`timescale 1ns / 1ps
package sac_pkg;

  localparam int DEF_MAX_SET_BITS = 8;
  localparam int DEF_MAX_WAYS     = 8;

  localparam int ADDR_W  = 64;
  localparam int CNT_W   = 32;
  localparam int SB_W    = 5;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef logic [1:0] outcome_t;
  localparam outcome_t OUT_HIT   = 2'd0;
  localparam outcome_t OUT_FILL  = 2'd1;
  localparam outcome_t OUT_EVICT = 2'd2;

  localparam logic [1:0] REG_SET_BITS    = 2'd0;
  localparam logic [1:0] REG_WAYS        = 2'd1;
  localparam logic [1:0] REG_OFFSET_BITS = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] address;
  } in_beat_t;

  typedef struct packed {
    outcome_t         outcome;
    logic             last;
    logic [CNT_W-1:0] total_hits;
    logic [CNT_W-1:0] total_misses;
    logic [CNT_W-1:0] total_evictions;
  } out_beat_t;

endpackage

// ----- rtl/sac_ram.sv -----
`timescale 1ns / 1ps
module sac_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/sac_way_sel.sv -----
`timescale 1ns / 1ps
module sac_way_sel import sac_pkg::*; #(
  parameter int MAX_WAYS = DEF_MAX_WAYS,
  parameter int FILL_W   = $clog2(MAX_WAYS + 1),
  parameter int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  logic [MAX_WAYS*ADDR_W-1:0] tags_row,
  input  logic [MAX_WAYS*ADDR_W-1:0] stamps_row,
  input  logic [FILL_W-1:0]          fill,
  input  logic [FILL_W-1:0]          limit,
  input  logic [ADDR_W-1:0]          tag,
  output outcome_t                   outcome,
  output logic [WAY_W-1:0]           way
);

  localparam int LVL = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;
  localparam int P   = 1 << LVL;

  logic [MAX_WAYS-1:0] match;
  logic                hit;
  logic [WAY_W-1:0]    hit_way;

  logic [ADDR_W-1:0] nd_stamp [1:2*P-1];
  logic              nd_v     [1:2*P-1];
  logic [WAY_W-1:0]  nd_way   [1:2*P-1];

  always_comb begin
    hit_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      match[i] = (i < int'(fill)) && (tags_row[i*ADDR_W +: ADDR_W] == tag);
      if (match[i]) begin
        hit_way = WAY_W'(i);
      end
    end
    hit = |match;
  end

  // min tree over the filled ways, left wins a tie so the lowest way is kept
  always_comb begin
    for (int i = 0; i < P; i++) begin
      nd_way[P+i] = WAY_W'(i);
      if (i < MAX_WAYS) begin
        nd_stamp[P+i] = stamps_row[i*ADDR_W +: ADDR_W];
        nd_v[P+i]     = (i < int'(fill));
      end else begin
        nd_stamp[P+i] = '0;
        nd_v[P+i]     = 1'b0;
      end
    end
    for (int k = P - 1; k >= 1; k--) begin
      if (nd_v[2*k+1] && (!nd_v[2*k] || (nd_stamp[2*k+1] < nd_stamp[2*k]))) begin
        nd_stamp[k] = nd_stamp[2*k+1];
        nd_v[k]     = 1'b1;
        nd_way[k]   = nd_way[2*k+1];
      end else begin
        nd_stamp[k] = nd_stamp[2*k];
        nd_v[k]     = nd_v[2*k];
        nd_way[k]   = nd_way[2*k];
      end
    end
  end

  always_comb begin
    priority if (hit) begin
      outcome = OUT_HIT;
      way     = hit_way;
    end else if (fill < limit) begin
      outcome = OUT_FILL;
      way     = fill[WAY_W-1:0];
    end else begin
      outcome = OUT_EVICT;
      way     = nd_way[1];
    end
  end

endmodule

// ----- rtl/set_assoc_lru_cache_sim.sv -----
`timescale 1ns / 1ps
// Set-associative cache simulator with LRU replacement. Each input beat is one
// access (mode 0) or a modify (mode 1, two accesses, two result beats). A set's
// tags and stamps live as one row each in memory; every access reads the row
// (registered read) and then decides and writes it back; that step waits
// while an earlier result beat is still untaken. After reset a clearing pass
// zeroes the per-set fill counts and clocks, one set a cycle, until all
// 2**MAX_SET_BITS sets (256 by default) are clear; no input is taken during
// it, configuration writes are. Registers at byte addresses 0, 4, 8: set_bits,
// ways, offset_bits; write them only while idle.
module set_assoc_lru_cache_sim import sac_pkg::*; #(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_beat_t          in_beat,
  output logic              out_valid,
  input  logic              out_ready,
  output out_beat_t         out_beat,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int AW       = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int FILL_W   = $clog2(MAX_WAYS + 1);
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ROW_W    = MAX_WAYS * ADDR_W;
  localparam int META_W   = ADDR_W + FILL_W;
  localparam logic [AW-1:0] LAST_SET = AW'(NUM_SETS - 1);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_EXE  = 2'd2;
  localparam logic [1:0] ST_RD   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [AW-1:0]     set_r;
  logic [ADDR_W-1:0] tag_r;
  logic              second_r, second_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_beat_r;
  logic [CNT_W-1:0]  hits_r, misses_r, evicts_r;
  logic [CNT_W-1:0]  hits_nxt, misses_nxt, evicts_nxt;

  logic [3:0] set_bits_r, ways_r;
  logic [5:0] offset_bits_r;

  logic              cfg_wr;
  logic [SB_W-1:0]   sb_eff;
  logic [6:0]        tag_shift;
  logic [ADDR_W-1:0] addr_shifted;
  logic [ADDR_W-1:0] tag_in;
  logic [SET_W-1:0]  set_mask;
  logic [AW-1:0]     set_in;
  logic [FILL_W-1:0] limit;

  logic              accept, exe_go, rd_en;
  logic [AW-1:0]     raddr;
  logic [ROW_W-1:0]  tags_row, stamps_row, tags_wr, stamps_wr;
  logic [META_W-1:0] meta_rd, meta_wr;
  logic              meta_we;
  logic [AW-1:0]     meta_waddr;
  logic [ADDR_W-1:0] clk_cur, clk_new;
  logic [FILL_W-1:0] fill_cur, fill_new;
  outcome_t          outcome;
  logic [WAY_W-1:0]  sel_way;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r    <= '0;
      ways_r        <= 4'd1;
      offset_bits_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SET_BITS:    set_bits_r    <= pwdata[3:0];
        REG_WAYS:        ways_r        <= pwdata[3:0];
        REG_OFFSET_BITS: offset_bits_r <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SET_BITS:    prdata = {28'd0, set_bits_r};
      REG_WAYS:        prdata = {28'd0, ways_r};
      REG_OFFSET_BITS: prdata = {26'd0, offset_bits_r};
      default:         prdata = '0;
    endcase
  end

  // address split and effective geometry
  always_comb begin
    if (int'(set_bits_r) > MAX_SET_BITS) begin
      sb_eff = SB_W'(MAX_SET_BITS);
    end else begin
      sb_eff = {1'b0, set_bits_r};
    end
    if (ways_r == 4'd0) begin
      limit = FILL_W'(1);
    end else if (int'(ways_r) > MAX_WAYS) begin
      limit = FILL_W'(MAX_WAYS);
    end else begin
      limit = FILL_W'(ways_r);
    end
    tag_shift    = {1'b0, offset_bits_r} + {2'b00, sb_eff};
    addr_shifted = in_beat.address >> offset_bits_r;
    tag_in       = in_beat.address >> tag_shift;
    set_mask     = ~({SET_W{1'b1}} << sb_eff);
    set_in       = AW'(addr_shifted[SET_W-1:0] & set_mask);
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid & in_ready;
  assign exe_go    = (state_r == ST_EXE) && (!out_valid_r || out_ready);
  assign rd_en     = accept || (state_r == ST_RD);
  assign raddr     = (state_r == ST_RD) ? set_r : set_in;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  assign clk_cur  = meta_rd[META_W-1:FILL_W];
  assign fill_cur = meta_rd[FILL_W-1:0];
  assign clk_new  = clk_cur + 1'b1;
  assign fill_new = (outcome == OUT_FILL) ? fill_cur + 1'b1 : fill_cur;

  sac_way_sel #(
    .MAX_WAYS(MAX_WAYS),
    .FILL_W  (FILL_W),
    .WAY_W   (WAY_W)
  ) u_way_sel (
    .tags_row  (tags_row),
    .stamps_row(stamps_row),
    .fill      (fill_cur),
    .limit     (limit),
    .tag       (tag_r),
    .outcome   (outcome),
    .way       (sel_way)
  );

  // row write-back with the chosen way replaced
  always_comb begin
    tags_wr   = tags_row;
    stamps_wr = stamps_row;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (sel_way == WAY_W'(i)) begin
        tags_wr[i*ADDR_W +: ADDR_W]   = tag_r;
        stamps_wr[i*ADDR_W +: ADDR_W] = clk_new;
      end
    end
  end

  always_comb begin
    if (state_r == ST_CLR) begin
      meta_we    = 1'b1;
      meta_waddr = clr_r;
      meta_wr    = '0;
    end else begin
      meta_we    = exe_go;
      meta_waddr = set_r;
      meta_wr    = {clk_new, fill_new};
    end
  end

  sac_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS), .AW(AW)) u_tags (
    .clk  (clk),
    .we   (exe_go),
    .waddr(set_r),
    .wdata(tags_wr),
    .re   (rd_en),
    .raddr(raddr),
    .rdata(tags_row)
  );

  sac_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS), .AW(AW)) u_stamps (
    .clk  (clk),
    .we   (exe_go),
    .waddr(set_r),
    .wdata(stamps_wr),
    .re   (rd_en),
    .raddr(raddr),
    .rdata(stamps_row)
  );

  sac_ram #(.WIDTH(META_W), .DEPTH(NUM_SETS), .AW(AW)) u_meta (
    .clk  (clk),
    .we   (meta_we),
    .waddr(meta_waddr),
    .wdata(meta_wr),
    .re   (rd_en),
    .raddr(raddr),
    .rdata(meta_rd)
  );

  // saturating totals
  always_comb begin
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    evicts_nxt = evicts_r;
    if (exe_go) begin
      if (outcome == OUT_HIT) begin
        if (hits_r != COUNT_MAX) hits_nxt = hits_r + 1'b1;
      end else begin
        if (misses_r != COUNT_MAX) misses_nxt = misses_r + 1'b1;
        if (outcome == OUT_EVICT && evicts_r != COUNT_MAX) evicts_nxt = evicts_r + 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    second_nxt    = second_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_SET) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          second_nxt = in_beat.mode;
          state_nxt  = ST_EXE;
        end
      end
      ST_EXE: begin
        if (exe_go) begin
          out_valid_nxt = 1'b1;
          second_nxt    = 1'b0;
          state_nxt     = second_r ? ST_RD : ST_IDLE;
        end
      end
      ST_RD: begin
        state_nxt = ST_EXE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      evicts_r    <= evicts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_r <= set_in;
      tag_r <= tag_in;
    end
    if (exe_go) begin
      out_beat_r.outcome         <= outcome;
      out_beat_r.last            <= !second_r;
      out_beat_r.total_hits      <= hits_nxt;
      out_beat_r.total_misses    <= misses_nxt;
      out_beat_r.total_evictions <= evicts_nxt;
    end
  end

endmodule

// ----- sim/set_assoc_lru_cache_sim_tb.sv -----
`timescale 1ns / 1ps
module set_assoc_lru_cache_sim_tb;
  import sac_pkg::*;

  localparam int SETS          = 1 << DEF_MAX_SET_BITS;
  localparam int WAYS          = DEF_MAX_WAYS;
  localparam int QUIET_CYCLES  = 8;
  localparam int STEADY_FROM   = 700;
  localparam int STEADY_TO     = 1000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 210;

  typedef enum logic [1:0] {STIM_ITEM, STIM_CFG, STIM_DRAIN} stim_kind_t;

  typedef struct {
    stim_kind_t        kind;
    logic [1:0]        reg_sel;
    logic [APB_DW-1:0] value;
    in_beat_t          beat;
  } stim_entry_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_beat_t          in_beat   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_beat_t         out_beat;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [APB_AW-1:0] paddr     = '0;
  logic [APB_DW-1:0] pwdata    = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  set_assoc_lru_cache_sim dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // shadow copy of the cache contents and settings
  logic [ADDR_W-1:0] line_tag   [SETS][WAYS];
  logic [63:0]       line_stamp [SETS][WAYS];
  int unsigned       set_fill   [SETS];
  logic [63:0]       set_clock  [SETS];
  logic [CNT_W-1:0]  hits       = '0;
  logic [CNT_W-1:0]  misses     = '0;
  logic [CNT_W-1:0]  evictions  = '0;
  logic [3:0]        set_bits_q = 4'd0;
  logic [3:0]        ways_q     = 4'd1;
  logic [5:0]        offset_q   = 6'd0;

  stim_entry_t pending[$];
  out_beat_t   expected_beats[$];
  int unsigned beats_sent = 0;
  int unsigned quiet      = 0;
  int unsigned errors     = 0;
  logic        steady     = 1'b0;
  logic        stim_done  = 1'b0;

  int unsigned set_bits_pick [4] = '{3, 15, 8, 0};
  int unsigned ways_pick     [4] = '{4, 15, 1, 0};
  int unsigned offset_pick   [4] = '{6, 63, 0, 56};

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic outcome_t cache_access(int unsigned s, logic [ADDR_W-1:0] t);
    int unsigned lim;
    int unsigned fill;
    int unsigned victim;
    logic [63:0] least;
    lim  = (ways_q == 0) ? 1 : ((ways_q > WAYS) ? WAYS : ways_q);
    fill = set_fill[s];
    set_clock[s] = set_clock[s] + 64'd1;
    for (int i = 0; i < fill; i++) begin
      if (line_tag[s][i] == t) begin
        line_stamp[s][i] = set_clock[s];
        hits = bump(hits);
        return OUT_HIT;
      end
    end
    misses = bump(misses);
    if (fill < lim) begin
      line_tag[s][fill]   = t;
      line_stamp[s][fill] = set_clock[s];
      set_fill[s]         = fill + 1;
      return OUT_FILL;
    end
    // least recent stamp, first way wins a tie
    victim = 0;
    least  = line_stamp[s][0];
    for (int i = 1; i < fill; i++) begin
      if (line_stamp[s][i] < least) begin
        least  = line_stamp[s][i];
        victim = i;
      end
    end
    line_tag[s][victim]   = t;
    line_stamp[s][victim] = set_clock[s];
    evictions = bump(evictions);
    return OUT_EVICT;
  endfunction

  function automatic void predict_accesses(in_beat_t b);
    logic [63:0] a;
    logic [63:0] t;
    int unsigned sb;
    int unsigned s;
    int unsigned n;
    out_beat_t   r;
    a  = b.address >> offset_q;
    sb = (set_bits_q > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : set_bits_q;
    t  = a >> sb;
    s  = int'(a & ((64'd1 << sb) - 64'd1));
    n  = b.mode ? 2 : 1;
    for (int k = 0; k < n; k++) begin
      r.outcome         = cache_access(s, t);
      r.last            = (k == n - 1);
      r.total_hits      = hits;
      r.total_misses    = misses;
      r.total_evictions = evictions;
      expected_beats.push_back(r);
    end
  endfunction

  function automatic logic [63:0] compose(logic [63:0] tag, int unsigned set_idx,
                                          int unsigned sb, int unsigned off);
    logic [63:0] low;
    low = {$urandom, $urandom} & ((64'd1 << off) - 64'd1);
    return (((tag << sb) | 64'(set_idx)) << off) | low;
  endfunction

  function automatic void add_item(logic mode, logic [63:0] addr);
    stim_entry_t e;
    e.kind         = STIM_ITEM;
    e.reg_sel      = REG_SET_BITS;
    e.value        = '0;
    e.beat.mode    = mode;
    e.beat.address = addr;
    pending.push_back(e);
  endfunction

  function automatic void add_cfg(logic [1:0] sel, int unsigned val);
    stim_entry_t e;
    e.kind    = STIM_CFG;
    e.reg_sel = sel;
    e.value   = val;
    e.beat    = '0;
    pending.push_back(e);
  endfunction

  function automatic void add_drain();
    stim_entry_t e;
    e.kind    = STIM_DRAIN;
    e.reg_sel = REG_SET_BITS;
    e.value   = '0;
    e.beat    = '0;
    pending.push_back(e);
  endfunction

  task automatic flag_mismatch(string what, out_beat_t want, out_beat_t got);
    errors++;
    if (errors <= 10) begin
      $display("%s: expected outcome %0d last %0b hits %0d misses %0d evictions %0d",
               what, want.outcome, want.last, want.total_hits, want.total_misses,
               want.total_evictions);
      $display("  got outcome %0d last %0b hits %0d misses %0d evictions %0d",
               got.outcome, got.last, got.total_hits, got.total_misses,
               got.total_evictions);
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      stim_done <= 1'b0;
      quiet = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_accesses(in_beat);
        beats_sent++;
      end
      steady <= beats_sent >= STEADY_FROM && beats_sent < STEADY_TO;
      if (psel) begin
        if (!penable) begin
          penable <= 1'b1;
        end else if (pready) begin
          case (pending[0].reg_sel)
            REG_SET_BITS:    set_bits_q = pending[0].value[3:0];
            REG_WAYS:        ways_q     = pending[0].value[3:0];
            REG_OFFSET_BITS: offset_q   = pending[0].value[5:0];
            default: ;
          endcase
          void'(pending.pop_front());
          psel    <= 1'b0;
          penable <= 1'b0;
          pwrite  <= 1'b0;
        end
      end else if (!(in_valid && !in_ready)) begin
        if (pending.size() == 0) begin
          in_valid  <= 1'b0;
          stim_done <= 1'b1;
        end else if (pending[0].kind == STIM_ITEM) begin
          if (!steady && $urandom_range(99) < 31) begin
            in_valid <= 1'b0;
          end else begin
            in_valid <= 1'b1;
            in_beat  <= pending[0].beat;
            void'(pending.pop_front());
          end
        end else begin
          // hold off until every outstanding result is back and the block settles
          in_valid <= 1'b0;
          quiet = (expected_beats.size() == 0) ? quiet + 1 : 0;
          if (quiet >= QUIET_CYCLES) begin
            quiet = 0;
            if (pending[0].kind == STIM_DRAIN) begin
              void'(pending.pop_front());
            end else begin
              psel   <= 1'b1;
              pwrite <= 1'b1;
              paddr  <= {pending[0].reg_sel, 2'b00};
              pwdata <= pending[0].value;
            end
          end
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          flag_mismatch("result beat with nothing expected", '0, out_beat);
        end else begin
          want = expected_beats.pop_front();
          if (out_beat.outcome !== want.outcome || out_beat.last !== want.last ||
              out_beat.total_hits !== want.total_hits ||
              out_beat.total_misses !== want.total_misses ||
              out_beat.total_evictions !== want.total_evictions)
            flag_mismatch("result mismatch", want, out_beat);
        end
      end
      out_ready <= steady || $urandom_range(99) >= 31;
    end
  end

  initial begin
    int unsigned sb;
    int unsigned wy;
    int unsigned off;
    int unsigned sbe;
    int unsigned wye;
    int unsigned nsets;
    int unsigned ntags;
    int unsigned set_pool [4];
    logic [63:0] tag_pool [16];
    logic [63:0] addr;

    for (int s = 0; s < SETS; s++) begin
      set_fill[s]  = 0;
      set_clock[s] = '0;
    end

    // reset settings: one set, one way, no offset
    add_item(1'b0, 64'd0);
    add_item(1'b0, 64'd0);
    add_item(1'b1, '1);
    add_item(1'b0, 64'd0);

    // three ways in set 1, lru victim choice
    add_cfg(REG_SET_BITS, 2);
    add_cfg(REG_WAYS, 3);
    add_cfg(REG_OFFSET_BITS, 3);
    add_item(1'b0, compose(64'd1, 1, 2, 3));
    add_item(1'b0, compose(64'd2, 1, 2, 3));
    add_item(1'b0, compose(64'd3, 1, 2, 3));
    add_item(1'b0, compose(64'd1, 1, 2, 3));
    add_item(1'b0, compose(64'd4, 1, 2, 3));
    add_item(1'b1, compose(64'd2, 1, 2, 3));
    add_item(1'b0, compose(64'd1, 1, 2, 3));

    // ways lowered below the fill count
    add_cfg(REG_WAYS, 1);
    add_item(1'b0, compose(64'd4, 1, 2, 3));
    add_item(1'b0, compose(64'd9, 1, 2, 3));

    // oversized set bits and ways, widest offset
    add_cfg(REG_SET_BITS, 15);
    add_cfg(REG_WAYS, 15);
    add_cfg(REG_OFFSET_BITS, 63);
    add_item(1'b0, 64'd0);
    add_item(1'b0, 64'h8000_0000_0000_0000);
    add_item(1'b1, '1);
    add_item(1'b0, 64'h7fff_ffff_ffff_ffff);

    // zero ways acts as one
    add_cfg(REG_SET_BITS, 8);
    add_cfg(REG_WAYS, 0);
    add_cfg(REG_OFFSET_BITS, 0);
    add_item(1'b0, 64'h155);
    add_item(1'b0, 64'h1155);
    add_item(1'b1, 64'h1155);
    add_item(1'b0, 64'hffff_ffff_ffff_ff55);

    for (int p = 0; p < PHASES; p++) begin
      sb  = (p < 4) ? set_bits_pick[p] : $urandom_range(15);
      wy  = (p < 4) ? ways_pick[p]     : $urandom_range(15);
      off = (p < 4) ? offset_pick[p]   : $urandom_range(63);
      add_cfg(REG_SET_BITS, sb);
      add_cfg(REG_WAYS, wy);
      add_cfg(REG_OFFSET_BITS, off);
      sbe   = (sb > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : sb;
      wye   = (wy == 0) ? 1 : ((wy > WAYS) ? WAYS : wy);
      nsets = $urandom_range(1, 3);
      ntags = wye + $urandom_range(1, 3);
      for (int j = 0; j < nsets; j++)
        set_pool[j] = $urandom_range((1 << sbe) - 1);
      for (int j = 0; j < ntags; j++)
        tag_pool[j] = {$urandom, $urandom};
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == PHASE_ITEMS / 2)
          add_drain();
        if ($urandom_range(99) < 15)
          addr = {$urandom, $urandom};
        else
          addr = compose(tag_pool[$urandom_range(ntags - 1)],
                         set_pool[$urandom_range(nsets - 1)], sbe, off);
        add_item($urandom_range(99) < 30, addr);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (!stim_done) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sac_pkg.sv
rtl/sac_ram.sv
rtl/sac_way_sel.sv
rtl/set_assoc_lru_cache_sim.sv
sim/set_assoc_lru_cache_sim_tb.sv
